// ===== rtl/tkpq_pkg.sv =====
// Shared types, codes and default sizes for the two-key priority queue.
`default_nettype none

package tkpq_pkg;

    // Default sizes handed to the top level parameters.
    localparam int unsigned TKPQ_QUEUE_DEPTH   = 16;
    localparam int unsigned TKPQ_PRIORITY_BITS = 8;
    localparam int unsigned TKPQ_PAYLOAD_BITS  = 64;

    // Transaction kinds carried in s_tuser.
    typedef enum logic {
        ACT_ENQUEUE = 1'b0,
        ACT_DEQUEUE = 1'b1
    } tkpq_action_t;

    // Result status carried in m_tuser.
    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } tkpq_status_t;

    // Command broadcast from the controller to every cell in the chain.
    typedef struct packed {
        logic insert;
        logic remove;
    } tkpq_op_t;

endpackage : tkpq_pkg

`default_nettype wire

// ===== rtl/two_key_priority_queue_core.sv =====
// Top level of the two-key priority queue: handshake, fill count and cell chain.
`default_nettype none

// Bounded priority queue built as a chain of compare-and-shift cells. Entries
// leave by major key (higher first), then minor key (higher first), then in
// arrival order. Every transaction on the s_ side, enqueue or dequeue, yields
// exactly one transaction on the m_ side. All cells compare against the new
// key in parallel and shift by one place, so a new transaction is taken every
// clock while the result register is free or being drained. An enqueue into a
// full queue or a dequeue from an empty one leaves the queue unchanged and is
// flagged in m_tuser.
module two_key_priority_queue_core
    import tkpq_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH   = TKPQ_QUEUE_DEPTH,
    parameter int unsigned PRIORITY_BITS = TKPQ_PRIORITY_BITS,
    parameter int unsigned PAYLOAD_BITS  = TKPQ_PAYLOAD_BITS,
    localparam int unsigned KEY_BITS     = 2 * PRIORITY_BITS,
    localparam int unsigned COUNT_BITS   = $clog2(QUEUE_DEPTH + 1),
    localparam int unsigned S_RAW_BITS   = KEY_BITS + PAYLOAD_BITS,
    localparam int unsigned S_DATA_BITS  = ((S_RAW_BITS + 7) / 8) * 8,
    localparam int unsigned M_RAW_BITS   = KEY_BITS + PAYLOAD_BITS + COUNT_BITS,
    localparam int unsigned M_DATA_BITS  = ((M_RAW_BITS + 7) / 8) * 8
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    // Input channel.
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // tdata from bit 0: major_priority, minor_priority, payload, zero fill.
    input  wire logic [S_DATA_BITS-1:0] s_tdata,
    // tuser: action.
    input  wire logic                   s_tuser,
    // Result channel.
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // tdata from bit 0: out_major, out_minor, out_payload, occupancy, zero fill.
    output logic [M_DATA_BITS-1:0]      m_tdata,
    // tuser: status.
    output logic [1:0]                  m_tuser
);

    localparam logic [COUNT_BITS-1:0] DEPTH_C = COUNT_BITS'(QUEUE_DEPTH);

    logic                      accept;
    logic                      is_dequeue;
    logic                      full;
    logic                      empty;
    tkpq_op_t                  op;
    logic [PRIORITY_BITS-1:0]  in_major;
    logic [PRIORITY_BITS-1:0]  in_minor;
    logic [PAYLOAD_BITS-1:0]   in_payload;
    logic [KEY_BITS-1:0]       in_key;

    logic [COUNT_BITS-1:0]     count_reg;
    logic [COUNT_BITS-1:0]     count_next;

    logic                      m_valid_reg;
    logic                      m_valid_next;
    tkpq_status_t              status_reg;
    tkpq_status_t              status_next;
    logic [KEY_BITS-1:0]       out_key_reg;
    logic [KEY_BITS-1:0]       out_key_next;
    logic [PAYLOAD_BITS-1:0]   out_payload_reg;
    logic [PAYLOAD_BITS-1:0]   out_payload_next;
    logic [COUNT_BITS-1:0]     occupancy_reg;

    logic [QUEUE_DEPTH-1:0]    cell_keep;
    logic [KEY_BITS-1:0]       cell_key     [QUEUE_DEPTH];
    logic [PAYLOAD_BITS-1:0]   cell_payload [QUEUE_DEPTH];

    // Unpack the incoming transaction.
    assign in_major   = s_tdata[PRIORITY_BITS-1:0];
    assign in_minor   = s_tdata[KEY_BITS-1:PRIORITY_BITS];
    assign in_payload = s_tdata[S_RAW_BITS-1:KEY_BITS];
    assign in_key     = {in_major, in_minor};
    assign is_dequeue = (s_tuser == ACT_DEQUEUE);

    // The result register frees up when empty or when it is being taken.
    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign full  = (count_reg == DEPTH_C);
    assign empty = (count_reg == '0);

    assign op.insert = accept && !is_dequeue && !full;
    assign op.remove = accept && is_dequeue && !empty;

    // Fill count and the result that goes with each transaction.
    always_comb begin
        count_next       = count_reg;
        m_valid_next     = m_valid_reg && !m_tready;
        status_next      = status_reg;
        out_key_next     = out_key_reg;
        out_payload_next = out_payload_reg;
        if (accept) begin
            m_valid_next     = 1'b1;
            status_next      = STATUS_OK;
            out_key_next     = '0;
            out_payload_next = '0;
            if (!is_dequeue) begin
                if (full) begin
                    status_next = STATUS_FULL;
                end else begin
                    count_next = count_reg + 1'b1;
                end
            end else begin
                if (empty) begin
                    status_next = STATUS_EMPTY;
                end else begin
                    count_next       = count_reg - 1'b1;
                    out_key_next     = cell_key[0];
                    out_payload_next = cell_payload[0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Result payload registers need no reset.
    always_ff @(posedge aclk) begin
        status_reg      <= status_next;
        out_key_reg     <= out_key_next;
        out_payload_reg <= out_payload_next;
        if (accept) begin
            occupancy_reg <= count_next;
        end
    end

    // Chain of cells, head at position zero.
    for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
        logic                    prev_keep;
        logic [KEY_BITS-1:0]     prev_key;
        logic [PAYLOAD_BITS-1:0] prev_payload;
        logic [KEY_BITS-1:0]     next_key;
        logic [PAYLOAD_BITS-1:0] next_payload;
        logic                    occupied;

        assign occupied = (COUNT_BITS'(i) < count_reg);

        if (i == 0) begin : g_head
            assign prev_keep    = 1'b1;
            assign prev_key     = in_key;
            assign prev_payload = in_payload;
        end else begin : g_body
            assign prev_keep    = cell_keep[i-1];
            assign prev_key     = cell_key[i-1];
            assign prev_payload = cell_payload[i-1];
        end

        if (i == QUEUE_DEPTH - 1) begin : g_tail
            assign next_key     = in_key;
            assign next_payload = in_payload;
        end else begin : g_inner
            assign next_key     = cell_key[i+1];
            assign next_payload = cell_payload[i+1];
        end

        tkpq_cell #(
            .KEY_BITS     (KEY_BITS),
            .PAYLOAD_BITS (PAYLOAD_BITS)
        ) u_cell (
            .aclk         (aclk),
            .op           (op),
            .occupied     (occupied),
            .new_key      (in_key),
            .new_payload  (in_payload),
            .prev_keep    (prev_keep),
            .prev_key     (prev_key),
            .prev_payload (prev_payload),
            .next_key     (next_key),
            .next_payload (next_payload),
            .keep         (cell_keep[i]),
            .key          (cell_key[i]),
            .payload      (cell_payload[i])
        );
    end

    // Pack the result channel.
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = status_reg;

    always_comb begin
        m_tdata = '0;
        m_tdata[PRIORITY_BITS-1:0]            = out_key_reg[KEY_BITS-1:PRIORITY_BITS];
        m_tdata[KEY_BITS-1:PRIORITY_BITS]     = out_key_reg[PRIORITY_BITS-1:0];
        m_tdata[S_RAW_BITS-1:KEY_BITS]        = out_payload_reg;
        m_tdata[M_RAW_BITS-1:S_RAW_BITS]      = occupancy_reg;
    end

    // The fill count never passes the depth.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= DEPTH_C)
        else $error("fill count above queue depth");

    // A successful enqueue grows the queue by exactly one entry.
    a_enqueue_count: assert property (@(posedge aclk) disable iff (!aresetn)
        op.insert |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("enqueue did not add one entry");

    // A dequeue from an empty queue is reported as such.
    a_empty_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && is_dequeue && empty) |=> (m_tuser == STATUS_EMPTY) && m_tvalid)
        else $error("empty dequeue not flagged");

    // The two front entries are kept in order.
    a_head_sorted: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg >= COUNT_BITS'(2)) |-> (cell_key[0] >= cell_key[1]))
        else $error("head entries out of order");

endmodule : two_key_priority_queue_core

`default_nettype wire

// ===== rtl/tkpq_cell.sv =====
// One storage cell of the sorted chain: holds a key pair and a payload.
`default_nettype none

module tkpq_cell
    import tkpq_pkg::*;
#(
    parameter int unsigned KEY_BITS     = 2 * TKPQ_PRIORITY_BITS,
    parameter int unsigned PAYLOAD_BITS = TKPQ_PAYLOAD_BITS
) (
    input  wire logic                    aclk,
    input  wire tkpq_op_t                op,
    input  wire logic                    occupied,
    input  wire logic [KEY_BITS-1:0]     new_key,
    input  wire logic [PAYLOAD_BITS-1:0] new_payload,
    input  wire logic                    prev_keep,
    input  wire logic [KEY_BITS-1:0]     prev_key,
    input  wire logic [PAYLOAD_BITS-1:0] prev_payload,
    input  wire logic [KEY_BITS-1:0]     next_key,
    input  wire logic [PAYLOAD_BITS-1:0] next_payload,
    output logic                         keep,
    output logic [KEY_BITS-1:0]          key,
    output logic [PAYLOAD_BITS-1:0]      payload
);

    logic [KEY_BITS-1:0]     key_reg;
    logic [KEY_BITS-1:0]     key_next;
    logic [PAYLOAD_BITS-1:0] payload_reg;
    logic [PAYLOAD_BITS-1:0] payload_next;

    // A stored entry stays in place when it ranks at or above the new one,
    // so that equal keys keep their arrival order.
    assign keep = occupied && (key_reg >= new_key);

    // On insert the first cell that does not keep takes the new entry and
    // every cell behind it takes its left neighbour; on remove all shift left.
    always_comb begin
        key_next     = key_reg;
        payload_next = payload_reg;
        if (op.insert) begin
            if (!keep) begin
                if (prev_keep) begin
                    key_next     = new_key;
                    payload_next = new_payload;
                end else begin
                    key_next     = prev_key;
                    payload_next = prev_payload;
                end
            end
        end else if (op.remove) begin
            key_next     = next_key;
            payload_next = next_payload;
        end
    end

    // Entry storage; positions past the fill count hold no valid entry and never reach the result.
    always_ff @(posedge aclk) begin
        key_reg     <= key_next;
        payload_reg <= payload_next;
    end

    assign key     = key_reg;
    assign payload = payload_reg;

endmodule : tkpq_cell

`default_nettype wire
